/* hw/rtl/matrix_keypad_autorepeat_core_macros.svh */
// assertion macros for the keypad autorepeat core
// used by the rtl files that check their own logic; empty bodies under synthesis
`ifndef MATRIX_KEYPAD_AUTOREPEAT_CORE_MACROS_SVH
`define MATRIX_KEYPAD_AUTOREPEAT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MKAR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("mkar assertion failed");
`define MKAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mkar assertion failed");
`define MKAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mkar assertion failed");
`else
`define MKAR_ASSERT(label, clk, rst_n, prop)
`define MKAR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MKAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/mkar_pkg.sv */
// shared types, constants and the key character map of the keypad autorepeat core
// no dependencies
package mkar_pkg;

	localparam int KEY_ROWS = 4;
	localparam int KEY_COLS = 4;
	localparam int NUM_KEYS = KEY_ROWS * KEY_COLS;
	localparam int KEY_IDX_W = $clog2(NUM_KEYS);

	localparam logic [15:0] SCAN_INTERVAL_RST = 16'd25;
	localparam logic [15:0] FIRST_REPEAT_RST = 16'd400;
	localparam logic [15:0] NEXT_REPEAT_RST = 16'd125;

	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_SCAN_INTERVAL = 2'd0,
		REG_FIRST_REPEAT = 2'd1,
		REG_NEXT_REPEAT = 2'd2
	} reg_idx_t;

	// column-major: bit col*4+row
	localparam logic [NUM_KEYS-1:0][7:0] KEY_MAP = {
		"H", "D", "T", "P",
		"Y", "9", "6", "3",
		"0", "8", "5", "2",
		"N", "7", "4", "1"
	};

	typedef struct packed {
		logic [15:0] scan_interval_ms;
		logic [15:0] first_repeat_ms;
		logic [15:0] next_repeat_ms;
	} cfg_t;

	typedef struct packed {
		logic [7:0] key_code;
		logic       beep;
		logic       click;
	} res_t;

	function automatic logic [7:0] key_char(input logic [KEY_IDX_W-1:0] idx);
		return KEY_MAP[idx];
	endfunction

endpackage

/* hw/rtl/mkar_cfg.sv */
// apb configuration registers of the keypad autorepeat core
// depends on mkar_pkg
module mkar_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mkar_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output mkar_pkg::cfg_t              cfg
);

	mkar_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = paddr[3:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_interval_ms <= mkar_pkg::SCAN_INTERVAL_RST;
			cfg_q.first_repeat_ms <= mkar_pkg::FIRST_REPEAT_RST;
			cfg_q.next_repeat_ms <= mkar_pkg::NEXT_REPEAT_RST;
		end else if (wr_en) begin
			case (idx)
				mkar_pkg::REG_SCAN_INTERVAL: cfg_q.scan_interval_ms <= pwdata[15:0];
				mkar_pkg::REG_FIRST_REPEAT: cfg_q.first_repeat_ms <= pwdata[15:0];
				mkar_pkg::REG_NEXT_REPEAT: cfg_q.next_repeat_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mkar_pkg::REG_SCAN_INTERVAL: prdata = {16'd0, cfg_q.scan_interval_ms};
			mkar_pkg::REG_FIRST_REPEAT: prdata = {16'd0, cfg_q.first_repeat_ms};
			mkar_pkg::REG_NEXT_REPEAT: prdata = {16'd0, cfg_q.next_repeat_ms};
			default: prdata = 32'd0;
		endcase
	end

endmodule

/* hw/rtl/mkar_engine.sv */
// scan and typematic repeat logic with its key state registers
// depends on mkar_pkg and the assertion macro header
`include "matrix_keypad_autorepeat_core_macros.svh"
module mkar_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [31:0]                   now_ms,
	input  logic [mkar_pkg::NUM_KEYS-1:0] pressed_keys,
	input  mkar_pkg::cfg_t                cfg,
	output mkar_pkg::res_t                res
);

	logic [7:0]  held_q;
	logic [31:0] press_q;
	logic        rep_q;
	logic [7:0]  reported_q;
	logic [31:0] last_scan_q;

	logic [7:0]  held_n;
	logic [31:0] press_n;
	logic        rep_n;
	logic [31:0] last_scan_n;

	logic [mkar_pkg::KEY_IDX_W-1:0] hi_idx;
	logic        any_key;
	logic        multi_key;
	logic [7:0]  new_char;
	logic        scan_due;
	logic        found;
	logic [31:0] scan_gap;
	logic [31:0] hold_gap;
	logic [15:0] wait_ms;
	logic [7:0]  held_s;
	logic [31:0] press_s;
	logic        rep_s;

	// highest pressed key wins
	always_comb begin
		hi_idx = '0;
		for (int i = 0; i < mkar_pkg::NUM_KEYS; i++) begin
			if (pressed_keys[i]) begin
				hi_idx = mkar_pkg::KEY_IDX_W'(i);
			end
		end
	end

	assign any_key = |pressed_keys;
	assign multi_key = |(pressed_keys & (pressed_keys - 1'b1));
	assign new_char = any_key ? mkar_pkg::key_char(hi_idx) : 8'd0;
	assign scan_gap = now_ms - last_scan_q;
	assign scan_due = scan_gap > {16'd0, cfg.scan_interval_ms};

	// state after the scan
	always_comb begin
		held_s = held_q;
		press_s = press_q;
		rep_s = rep_q;
		found = 1'b0;
		last_scan_n = last_scan_q;
		if (scan_due) begin
			last_scan_n = now_ms;
			held_s = new_char;
			found = any_key;
			if (!any_key) begin
				press_s = 32'd0;
				rep_s = 1'b0;
			end else if (multi_key || (new_char != held_q)) begin
				press_s = now_ms;
				rep_s = 1'b0;
			end
		end
	end

	assign wait_ms = rep_s ? cfg.next_repeat_ms : cfg.first_repeat_ms;
	assign hold_gap = now_ms - press_s;

	// report a change or a repeat
	always_comb begin
		held_n = held_s;
		press_n = press_s;
		rep_n = rep_s;
		res = '0;
		if (reported_q != held_s) begin
			res.key_code = held_s;
			res.beep = found;
		end else if ((held_s != 8'd0) && (hold_gap > {16'd0, wait_ms})) begin
			rep_n = 1'b1;
			press_n = now_ms;
			res.key_code = held_s;
			res.click = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 8'd0;
			press_q <= 32'd0;
			rep_q <= 1'b0;
			reported_q <= 8'd0;
			last_scan_q <= 32'd0;
		end else if (step) begin
			held_q <= held_n;
			press_q <= press_n;
			rep_q <= rep_n;
			reported_q <= held_n;
			last_scan_q <= last_scan_n;
		end
	end

	`MKAR_ASSERT(a_reported_tracks_held, clk, arst_n, reported_q == held_q)
	`MKAR_ASSERT_IMP(a_repeat_needs_key, clk, arst_n, rep_q, held_q != 8'd0)
	`MKAR_ASSERT_IMP(a_no_beep_and_click, clk, arst_n, step && res.beep, !res.click)
	`MKAR_ASSERT_NEXT(a_click_sets_repeat, clk, arst_n, step && res.click, rep_q && press_q == $past(now_ms))

endmodule

/* hw/rtl/matrix_keypad_autorepeat_core.sv */
// Matrix keypad scanner with typematic repeat.
// One poll item enters on the s_axis channel: tdata holds now_ms in bits 31:0 and
// the 16-bit key snapshot (bit col*4+row) in bits 47:32. Every poll gives exactly
// one result item on the m_axis channel: tdata is the key code (0 when nothing is
// reported), tuser bit 0 is beep (new key), bit 1 is click (auto-repeat).
// A poll is held in an input register, evaluated combinationally against the key
// state and written to the result register when it advances, which waits while a
// full result register waits on m_tready; one poll per cycle while s_tready is high.
// When m_tready is low a full result register holds; the input register still takes
// one more poll, and s_tready falls only while both registers are full.
// The three timing registers sit on the APB port at byte addresses 0, 4 and 8
// (scan interval, first repeat delay, repeat interval); pready is always high.
// Reset (arst_n low) clears the key state and both registers' valid flags and
// loads the timing registers with 25, 400 and 125 ms.
// depends on mkar_pkg, mkar_cfg, mkar_engine and the assertion macro header
module matrix_keypad_autorepeat_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [47:0]                 s_tdata,  // now_ms, pressed_keys
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,  // key_code
	output logic [1:0]                  m_tuser,  // beep, click
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mkar_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	mkar_pkg::cfg_t cfg;
	mkar_pkg::res_t res;

	logic                          valid_s1;
	logic [31:0]                   now_s1;
	logic [mkar_pkg::NUM_KEYS-1:0] keys_s1;
	logic                          valid_s2;
	mkar_pkg::res_t                res_s2;
	logic                          adv;
	logic                          in_fire;

	assign adv = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_fire = s_tvalid && s_tready;

	mkar_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mkar_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.now_ms       (now_s1),
		.pressed_keys (keys_s1),
		.cfg          (cfg),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_s1 <= s_tdata[31:0];
			keys_s1 <= s_tdata[47:32];
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = res_s2.key_code;
	assign m_tuser = {res_s2.click, res_s2.beep};

endmodule
